// ===== design/bssim_pkg.sv =====
// Shared types and constants for the bank switch scanline IRQ mapper.
// Holds the input and result word layouts, address decode codes and result kinds.
// Depends on nothing.
package bssim_pkg;

  typedef struct packed {
    logic       opcode;
    logic [15:0] address;
    logic [7:0] write_data;
    logic [8:0] scanline;
    logic       rendering_on;
  } in_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot;
    logic [8:0] value;
    logic       last;
  } out_word_t;

  // Input operations.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Address decode.
  localparam logic [15:0] ADDR_MASK     = 16'hF003;
  localparam logic [15:0] ADDR_BANK_SEL = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DAT = 16'h8001;
  localparam logic [15:0] ADDR_MIRROR   = 16'hA000;
  localparam logic [15:0] ADDR_IRQ_LATCH  = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_OFF  = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ON   = 16'hE001;

  // Result kinds.
  localparam logic [2:0] KIND_CPU    = 3'd1;
  localparam logic [2:0] KIND_PPU    = 3'd2;
  localparam logic [2:0] KIND_MIRROR = 3'd3;
  localparam logic [2:0] KIND_IRQ    = 3'd4;

  // Bank register indexes.
  localparam logic [3:0] BR_PPU_PAIR0 = 4'h0;
  localparam logic [3:0] BR_PPU_PAIR1 = 4'h1;
  localparam logic [3:0] BR_PPU_A     = 4'h2;
  localparam logic [3:0] BR_PPU_B     = 4'h3;
  localparam logic [3:0] BR_PPU_C     = 4'h4;
  localparam logic [3:0] BR_PPU_D     = 4'h5;
  localparam logic [3:0] BR_CPU_A     = 4'h6;
  localparam logic [3:0] BR_CPU_B     = 4'h7;
  localparam logic [3:0] BR_PPU_E     = 4'h8;
  localparam logic [3:0] BR_PPU_F     = 4'h9;
  localparam logic [3:0] BR_CPU_C     = 4'hF;

  // Result queue.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

endpackage

// ===== design/bank_switch_scanline_irq_mapper_top.sv =====
// Top level of the bank switch scanline IRQ mapper.
// Depends on bssim_pkg for word layouts and decode constants.
// Each accepted word registers its result words into the result queue.
// Throughput: one input word per cycle unless in_stall; a paired PPU bank write
//   yields two result words; output drains one per cycle unless out_stall.
// Reset (rst, synchronous, active high) clears all mapper state and empties
//   the result queue.
module bank_switch_scanline_irq_mapper_top #(
  parameter int LAST_VISIBLE_LINE = 239
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bssim_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bssim_pkg::out_word_t out_word
);

  // Mapper state.
  logic [3:0] reg_index;
  logic       prg_swap;
  logic       chr_invert;
  logic [7:0] irq_reload;
  logic [7:0] irq_count;
  logic       irq_on;

  // Result queue: a small ring of result words between the decode logic
  // and the output port. The input side stalls only when fewer than two
  // entries are free, which depends on registered state alone.
  bssim_pkg::out_word_t queue [bssim_pkg::QDEPTH];
  logic [bssim_pkg::QAW-1:0] wr_ptr;
  logic [bssim_pkg::QAW-1:0] rd_ptr;
  logic [bssim_pkg::QAW:0]   count;

  logic in_acc;
  logic out_acc;

  // Results of the word being accepted.
  bssim_pkg::out_word_t res0;
  bssim_pkg::out_word_t res1;
  logic [1:0]           res_n;

  logic [15:0] addr_dec;
  logic [8:0]  data_ext;
  logic [8:0]  data_inc;
  logic [7:0]  count_dec;
  logic        tick_active;

  logic [3:0] reg_index_next;
  logic       prg_swap_next;
  logic       chr_invert_next;
  logic [7:0] irq_reload_next;
  logic [7:0] irq_count_next;
  logic       irq_on_next;

  assign in_stall  = (count > (bssim_pkg::QAW+1)'(bssim_pkg::QDEPTH - 2));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign out_acc   = out_valid && !out_stall;
  assign out_word  = queue[rd_ptr];

  assign addr_dec  = in_word.address & bssim_pkg::ADDR_MASK;
  assign data_ext  = {1'b0, in_word.write_data};
  assign data_inc  = data_ext + 9'd1;
  assign count_dec = irq_count - 8'd1;
  // A tick counts only on a visible line with rendering and the IRQ enabled.
  assign tick_active = irq_on && in_word.rendering_on &&
                       (in_word.scanline <= 9'(LAST_VISIBLE_LINE));

  // Decode one word into up to two result words and the next mapper state.
  always_comb begin
    res0  = '0;
    res1  = '0;
    res_n = 2'd0;
    reg_index_next  = reg_index;
    prg_swap_next   = prg_swap;
    chr_invert_next = chr_invert;
    irq_reload_next = irq_reload;
    irq_count_next  = irq_count;
    irq_on_next     = irq_on;

    if (in_word.opcode == bssim_pkg::OP_TICK) begin
      if (tick_active) begin
        // On reaching zero the counter reloads and an IRQ is reported;
        // a counter already at zero wraps to 255 without an IRQ.
        if (count_dec == 8'd0) begin
          irq_count_next = irq_reload;
          res0.kind = bssim_pkg::KIND_IRQ;
          res_n     = 2'd1;
        end else begin
          irq_count_next = count_dec;
        end
      end
    end else begin
      unique case (addr_dec)
        bssim_pkg::ADDR_BANK_SEL: begin
          reg_index_next  = in_word.write_data[3:0];
          prg_swap_next   = in_word.write_data[6];
          chr_invert_next = in_word.write_data[7];
        end
        bssim_pkg::ADDR_BANK_DAT: begin
          res0.value = data_ext;
          res0.kind  = bssim_pkg::KIND_PPU;
          res_n      = 2'd1;
          unique case (reg_index)
            bssim_pkg::BR_PPU_PAIR0: begin
              res0.slot  = chr_invert ? 3'd4 : 3'd0;
              res1.kind  = bssim_pkg::KIND_PPU;
              res1.slot  = chr_invert ? 3'd5 : 3'd1;
              res1.value = data_inc;
              res_n      = 2'd2;
            end
            bssim_pkg::BR_PPU_PAIR1: begin
              res0.slot  = chr_invert ? 3'd6 : 3'd2;
              res1.kind  = bssim_pkg::KIND_PPU;
              res1.slot  = chr_invert ? 3'd7 : 3'd3;
              res1.value = data_inc;
              res_n      = 2'd2;
            end
            bssim_pkg::BR_PPU_A: res0.slot = chr_invert ? 3'd0 : 3'd4;
            bssim_pkg::BR_PPU_B: res0.slot = chr_invert ? 3'd1 : 3'd5;
            bssim_pkg::BR_PPU_C: res0.slot = chr_invert ? 3'd2 : 3'd6;
            bssim_pkg::BR_PPU_D: res0.slot = chr_invert ? 3'd3 : 3'd7;
            bssim_pkg::BR_CPU_A: begin
              res0.kind = bssim_pkg::KIND_CPU;
              res0.slot = prg_swap ? 3'd5 : 3'd4;
            end
            bssim_pkg::BR_CPU_B: begin
              res0.kind = bssim_pkg::KIND_CPU;
              res0.slot = prg_swap ? 3'd6 : 3'd5;
            end
            bssim_pkg::BR_PPU_E: res0.slot = 3'd1;
            bssim_pkg::BR_PPU_F: res0.slot = 3'd3;
            bssim_pkg::BR_CPU_C: begin
              res0.kind = bssim_pkg::KIND_CPU;
              res0.slot = prg_swap ? 3'd4 : 3'd6;
            end
            default: begin
              // Unused bank registers ignore the write.
              res0  = '0;
              res_n = 2'd0;
            end
          endcase
        end
        bssim_pkg::ADDR_MIRROR: begin
          res0.kind  = bssim_pkg::KIND_MIRROR;
          res0.value = {8'd0, in_word.write_data[0]};
          res_n      = 2'd1;
        end
        bssim_pkg::ADDR_IRQ_LATCH: begin
          irq_reload_next = in_word.write_data;
          irq_count_next  = in_word.write_data;
        end
        bssim_pkg::ADDR_IRQ_RELOAD: begin
          irq_count_next = irq_reload;
        end
        bssim_pkg::ADDR_IRQ_OFF: begin
          irq_on_next    = 1'b0;
          irq_count_next = irq_reload;
        end
        bssim_pkg::ADDR_IRQ_ON: begin
          irq_on_next    = 1'b1;
          irq_count_next = irq_reload;
        end
        default: begin
          // Undecoded addresses are ignored.
        end
      endcase
    end

    // The final result word of an item carries the last mark.
    if (res_n == 2'd1) begin
      res0.last = 1'b1;
    end
    if (res_n == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  // Mapper state updates on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_index  <= '0;
      prg_swap   <= 1'b0;
      chr_invert <= 1'b0;
      irq_reload <= '0;
      irq_count  <= '0;
      irq_on     <= 1'b0;
    end else if (in_acc) begin
      reg_index  <= reg_index_next;
      prg_swap   <= prg_swap_next;
      chr_invert <= chr_invert_next;
      irq_reload <= irq_reload_next;
      irq_count  <= irq_count_next;
      irq_on     <= irq_on_next;
    end
  end

  // Result queue storage; entries carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc && (res_n != 2'd0)) begin
      queue[wr_ptr] <= res0;
    end
    if (in_acc && (res_n == 2'd2)) begin
      queue[wr_ptr + 1'b1] <= res1;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr <= wr_ptr + bssim_pkg::QAW'(res_n);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (in_acc ? (bssim_pkg::QAW+1)'(res_n) : '0)
                     - (bssim_pkg::QAW+1)'(out_acc);
    end
  end

endmodule
